// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== src/drh_pkg.sv =====
`default_nettype none

package drh_pkg;

    localparam int MASK_W = 4;
    localparam int TICK_W = 16;
    localparam int CNT_W  = 3;

    localparam logic [15:0] GUIDE_TIMEOUT_RST = 16'd1000;

    // Stage codes
    localparam logic [2:0] ST_STAGE1 = 3'd0;
    localparam logic [2:0] ST_STAGE2 = 3'd1;
    localparam logic [2:0] ST_STAGE3 = 3'd2;
    localparam logic [2:0] ST_STAGE4 = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // LED modes
    localparam logic [1:0] LED_OFF    = 2'd0;
    localparam logic [1:0] LED_BEACON = 2'd1;
    localparam logic [1:0] LED_PROX   = 2'd2;

    // LED selections
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_TOP  = 2'd1;
    localparam logic [1:0] SEL_LR   = 2'd2;

    // One result as it travels on tdata, lowest field last in the list.
    typedef struct packed {
        logic       lockme_expected;
        logic       rx_enable;
        logic       rx_cmd_valid;
        logic       pulse_on;
        logic [1:0] led_select;
        logic [1:0] led_mode;
        logic       led_cmd_valid;
        logic [2:0] stage;
        logic [1:0] port;
    } res_t;

    // Per-port step outcome: new state plus the commands issued.
    typedef struct packed {
        logic [2:0]        st;
        logic [TICK_W-1:0] ticks;
        logic              dr;
        logic              gm;
        logic              lm;
        logic              lk;
        logic              ex;
        logic              led_v;
        logic [1:0]        led_m;
        logic [1:0]        led_s;
        logic              pulse;
        logic              rx_v;
        logic              rx_e;
    } step_t;

    function automatic step_t port_step(
        input logic [2:0]        st,
        input logic [TICK_W-1:0] ticks,
        input logic [TICK_W-1:0] tmo,
        input logic              dr,
        input logic              gm,
        input logic              lm,
        input logic              lk,
        input logic              ex
    );
        step_t s;
        logic  give_up;
        s       = '0;
        s.st    = st;
        s.ticks = ticks;
        s.dr    = dr;
        s.gm    = gm;
        s.lm    = lm;
        s.lk    = lk;
        s.ex    = ex;
        give_up = 1'b0;
        case (st)
            ST_STAGE1:
            begin
                if (dr)
                begin
                    s.dr    = 1'b0;
                    s.led_v = 1'b1;
                    s.led_m = LED_BEACON;
                    s.led_s = SEL_TOP;
                    s.pulse = 1'b1;
                end
                else if (gm)
                begin
                    s.gm    = 1'b0;
                    s.st    = ST_STAGE2;
                    s.led_v = 1'b1;
                    s.led_m = LED_PROX;
                    s.led_s = SEL_LR;
                end
            end
            ST_STAGE2:
            begin
                s.gm = 1'b0;
                s.ex = 1'b1;
                if (lm || lk)
                begin
                    s.st    = ST_STAGE3;
                    s.led_v = 1'b1;
                    s.led_m = LED_OFF;
                    s.led_s = SEL_LR;
                    s.rx_v  = 1'b1;
                    s.rx_e  = 1'b0;
                end
                if (dr)
                begin
                    give_up = 1'b1;
                end
                else
                begin
                    give_up = (ticks >= tmo);
                    s.ticks = ticks + 16'd1;
                end
                // giving up overrides any lock transition of this tick
                if (give_up)
                begin
                    s.dr    = 1'b0;
                    s.ticks = '0;
                    s.st    = ST_STAGE1;
                    s.led_v = 1'b1;
                    s.led_m = LED_OFF;
                    s.led_s = SEL_NONE;
                    s.pulse = 1'b0;
                    s.rx_v  = 1'b1;
                    s.rx_e  = 1'b1;
                end
            end
            ST_STAGE3:
            begin
                if (lm)
                begin
                    s.lm = 1'b0;
                    s.st = ST_STAGE4;
                end
                else if (lk)
                begin
                    s.lk = 1'b0;
                    s.st = ST_DONE;
                end
                else if (dr)
                begin
                    s.dr    = 1'b0;
                    s.ticks = '0;
                    s.st    = ST_STAGE1;
                    s.led_v = 1'b1;
                    s.led_m = LED_OFF;
                    s.led_s = SEL_NONE;
                    s.rx_v  = 1'b1;
                    s.rx_e  = 1'b1;
                end
                else if (gm)
                begin
                    s.gm    = 1'b0;
                    s.st    = ST_STAGE2;
                    s.led_v = 1'b1;
                    s.led_m = LED_PROX;
                    s.led_s = SEL_LR;
                end
            end
            ST_STAGE4:
            begin
                s.st = ST_DONE;
            end
            default:
            begin
                // done and unused codes hold
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/dock_recruit_handshake_fsm.sv =====
// Docking recruitment handshake for up to four ports. Each input transfer is one tick:
// its four message masks are ORed into per-port pending flags, every port steps its
// stage machine at once, and one result per port (port 0 first, tlast on the final
// port) leaves on the master side, one per cycle while m_tready is high, through that
// single result channel; the next tick is taken in the same cycle as the last result
// of the previous one transfers. guide_timeout is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle (not enforced here); it resets to 1000.
`default_nettype none

`include "assert_macros.svh"

module dock_recruit_handshake_fsm #(
    parameter int PORTS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // [3:0] docking_req_mask, [7:4] guideme_mask, [11:8] lockme_mask, [15:12] locked_mask
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] port, [4:2] stage, [5] led_cmd_valid, [7:6] led_mode, [9:8] led_select,
    // [10] pulse_on, [11] rx_cmd_valid, [12] rx_enable, [13] lockme_expected, [15:14] zero
    output logic [15:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    localparam int NPORT = (PORTS > 4) ? 4 : PORTS;
    localparam logic [drh_pkg::CNT_W-1:0] NPORT_CNT = drh_pkg::CNT_W'(NPORT);

    logic [15:0]                   guide_timeout_reg;
    logic [2:0]                    stage_reg [NPORT];
    logic [drh_pkg::TICK_W-1:0]    ticks_reg [NPORT];
    logic [NPORT-1:0]              pend_dr_reg;
    logic [NPORT-1:0]              pend_gm_reg;
    logic [NPORT-1:0]              pend_lm_reg;
    logic [NPORT-1:0]              pend_lk_reg;
    logic [NPORT-1:0]              expect_reg;

    drh_pkg::res_t                 buf_reg [NPORT];
    logic [drh_pkg::CNT_W-1:0]     cnt_reg;
    logic [drh_pkg::CNT_W-1:0]     cnt_next;

    drh_pkg::step_t                step_c [NPORT];
    drh_pkg::res_t                 res_c [NPORT];

    logic in_xfer;
    logic out_xfer;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == drh_pkg::CNT_W'(1));
    assign s_tready = (cnt_reg == '0) || (m_tlast && m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign m_tdata  = {2'b00, buf_reg[0]};

    always_comb
    begin
        for (int i = 0; i < NPORT; i++)
        begin
            step_c[i] = drh_pkg::port_step(
                stage_reg[i], ticks_reg[i], guide_timeout_reg,
                pend_dr_reg[i] | s_tdata[i],
                pend_gm_reg[i] | s_tdata[drh_pkg::MASK_W + i],
                pend_lm_reg[i] | s_tdata[2*drh_pkg::MASK_W + i],
                pend_lk_reg[i] | s_tdata[3*drh_pkg::MASK_W + i],
                expect_reg[i]);
            res_c[i].port            = 2'(i);
            res_c[i].stage           = step_c[i].st;
            res_c[i].led_cmd_valid   = step_c[i].led_v;
            res_c[i].led_mode        = step_c[i].led_m;
            res_c[i].led_select      = step_c[i].led_s;
            res_c[i].pulse_on        = step_c[i].pulse;
            res_c[i].rx_cmd_valid    = step_c[i].rx_v;
            res_c[i].rx_enable       = step_c[i].rx_e;
            res_c[i].lockme_expected = step_c[i].ex;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_xfer)
        begin
            cnt_next = NPORT_CNT;
        end
        else if (out_xfer)
        begin
            cnt_next = cnt_reg - drh_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guide_timeout_reg <= drh_pkg::GUIDE_TIMEOUT_RST;
            cnt_reg           <= '0;
            pend_dr_reg       <= '0;
            pend_gm_reg       <= '0;
            pend_lm_reg       <= '0;
            pend_lk_reg       <= '0;
            expect_reg        <= '0;
            for (int i = 0; i < NPORT; i++)
            begin
                stage_reg[i] <= drh_pkg::ST_STAGE1;
                ticks_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_we)
            begin
                guide_timeout_reg <= cfg_wdata;
            end
            if (in_xfer)
            begin
                for (int i = 0; i < NPORT; i++)
                begin
                    stage_reg[i]   <= step_c[i].st;
                    ticks_reg[i]   <= step_c[i].ticks;
                    pend_dr_reg[i] <= step_c[i].dr;
                    pend_gm_reg[i] <= step_c[i].gm;
                    pend_lm_reg[i] <= step_c[i].lm;
                    pend_lk_reg[i] <= step_c[i].lk;
                    expect_reg[i]  <= step_c[i].ex;
                end
            end
        end
    end

    // Result buffer: load a whole tick, then advance one port per transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < NPORT; i++)
            begin
                buf_reg[i] <= res_c[i];
            end
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < NPORT - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

    `ASSERT_NXT(a_load_full, in_xfer, m_tvalid && (cnt_reg == NPORT_CNT))
    `ASSERT_NXT(a_drain_step, out_xfer && !in_xfer, cnt_reg == $past(cnt_reg) - 3'd1)
    `ASSERT_IMP(a_last_frees_input, out_xfer && m_tlast, s_tready)
    `ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= NPORT_CNT)

endmodule

`default_nettype wire

// ===== verif/dock_recruit_handshake_fsm_tb.sv =====
module dock_recruit_handshake_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 90;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic last;
        drh_pkg::res_t r;
    } port_report_t;

    // Tracks the per-port docking stages and the reports each tick must produce.
    class dock_stage_tracker;
        port_report_t reports[$];
        int           errors;
        int           seen;
        logic [2:0]   stage_of [4];
        logic [15:0]  guided_for [4];
        logic [15:0]  give_up_after;
        logic [3:0]   dock_req;
        logic [3:0]   guide_req;
        logic [3:0]   lock_req;
        logic [3:0]   locked_req;
        logic [3:0]   awaiting_lock;

        function new();
            errors        = 0;
            seen          = 0;
            give_up_after = drh_pkg::GUIDE_TIMEOUT_RST;
            dock_req      = '0;
            guide_req     = '0;
            lock_req      = '0;
            locked_req    = '0;
            awaiting_lock = '0;
            for (int p = 0; p < 4; p++)
            begin
                stage_of[p]   = drh_pkg::ST_STAGE1;
                guided_for[p] = '0;
            end
        endfunction

        // One tick: merge the new message masks, then step ports 0..3 in order.
        function void take_tick(input logic [15:0] word);
            port_report_t rep;
            logic [2:0]   nxt;
            logic         quit;
            logic         lv;
            logic [1:0]   lmode;
            logic [1:0]   lsel;
            logic         pu;
            logic         rv;
            logic         re;
            dock_req   |= word[3:0];
            guide_req  |= word[7:4];
            lock_req   |= word[11:8];
            locked_req |= word[15:12];
            for (int p = 0; p < 4; p++)
            begin
                nxt = stage_of[p];
                {lv, lmode, lsel, pu, rv, re} = '0;
                case (stage_of[p])
                    drh_pkg::ST_STAGE1:
                    begin
                        if (dock_req[p])
                        begin
                            dock_req[p] = 1'b0;
                            {lv, lmode, lsel, pu} =
                                {1'b1, drh_pkg::LED_BEACON, drh_pkg::SEL_TOP, 1'b1};
                        end
                        else if (guide_req[p])
                        begin
                            guide_req[p] = 1'b0;
                            nxt = drh_pkg::ST_STAGE2;
                            {lv, lmode, lsel, pu} =
                                {1'b1, drh_pkg::LED_PROX, drh_pkg::SEL_LR, 1'b0};
                        end
                    end
                    drh_pkg::ST_STAGE2:
                    begin
                        guide_req[p]     = 1'b0;
                        awaiting_lock[p] = 1'b1;
                        if (lock_req[p] || locked_req[p])
                        begin
                            nxt = drh_pkg::ST_STAGE3;
                            {lv, lmode, lsel, pu} =
                                {1'b1, drh_pkg::LED_OFF, drh_pkg::SEL_LR, 1'b0};
                            {rv, re} = 2'b10;
                        end
                        if (dock_req[p])
                            quit = 1'b1;
                        else
                        begin
                            quit = guided_for[p] >= give_up_after;
                            guided_for[p] = guided_for[p] + 16'd1;
                        end
                        // a give-up replaces the lock commands of the same tick
                        if (quit)
                        begin
                            dock_req[p]   = 1'b0;
                            guided_for[p] = '0;
                            nxt = drh_pkg::ST_STAGE1;
                            {lv, lmode, lsel, pu} =
                                {1'b1, drh_pkg::LED_OFF, drh_pkg::SEL_NONE, 1'b0};
                            {rv, re} = 2'b11;
                        end
                    end
                    drh_pkg::ST_STAGE3:
                    begin
                        if (lock_req[p])
                        begin
                            lock_req[p] = 1'b0;
                            nxt = drh_pkg::ST_STAGE4;
                        end
                        else if (locked_req[p])
                        begin
                            locked_req[p] = 1'b0;
                            nxt = drh_pkg::ST_DONE;
                        end
                        else if (dock_req[p])
                        begin
                            dock_req[p]   = 1'b0;
                            guided_for[p] = '0;
                            nxt = drh_pkg::ST_STAGE1;
                            {lv, lmode, lsel, pu} =
                                {1'b1, drh_pkg::LED_OFF, drh_pkg::SEL_NONE, 1'b0};
                            {rv, re} = 2'b11;
                        end
                        else if (guide_req[p])
                        begin
                            guide_req[p] = 1'b0;
                            nxt = drh_pkg::ST_STAGE2;
                            {lv, lmode, lsel, pu} =
                                {1'b1, drh_pkg::LED_PROX, drh_pkg::SEL_LR, 1'b0};
                        end
                    end
                    drh_pkg::ST_STAGE4:
                        nxt = drh_pkg::ST_DONE;
                    default:
                        nxt = stage_of[p];
                endcase
                stage_of[p] = nxt;
                rep = '0;
                rep.r.port            = 2'(p);
                rep.r.stage           = nxt;
                rep.r.led_cmd_valid   = lv;
                rep.r.led_mode        = lmode;
                rep.r.led_select      = lsel;
                rep.r.pulse_on        = pu;
                rep.r.rx_cmd_valid    = rv;
                rep.r.rx_enable       = re;
                rep.r.lockme_expected = awaiting_lock[p];
                rep.last              = (p == 3);
                reports.push_back(rep);
            end
        endfunction

        function void compare_field(input string field, input int port, input int want,
                                    input int got);
            if (want != got)
            begin
                $display("%0t: port %0d %s expected %0d, got %0d", $time, port, field, want,
                         got);
                errors++;
            end
        endfunction

        function void match_report(input logic [15:0] word, input logic tl);
            port_report_t  want;
            drh_pkg::res_t got;
            got = drh_pkg::res_t'(word[13:0]);
            seen++;
            if (reports.size() == 0)
            begin
                $display("%0t: unexpected report %h (tlast %0b)", $time, word, tl);
                errors++;
                return;
            end
            want = reports.pop_front();
            compare_field("port", want.r.port, want.r.port, got.port);
            compare_field("stage", want.r.port, want.r.stage, got.stage);
            compare_field("led_cmd_valid", want.r.port, want.r.led_cmd_valid,
                          got.led_cmd_valid);
            compare_field("led_mode", want.r.port, want.r.led_mode, got.led_mode);
            compare_field("led_select", want.r.port, want.r.led_select, got.led_select);
            compare_field("pulse_on", want.r.port, want.r.pulse_on, got.pulse_on);
            compare_field("rx_cmd_valid", want.r.port, want.r.rx_cmd_valid,
                          got.rx_cmd_valid);
            compare_field("rx_enable", want.r.port, want.r.rx_enable, got.rx_enable);
            compare_field("lockme_expected", want.r.port, want.r.lockme_expected,
                          got.lockme_expected);
            compare_field("padding", want.r.port, 0, word[15:14]);
            compare_field("tlast", want.r.port, want.last, tl);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    logic        gaps_on   = 1'b1;
    logic        hold_ask  = 1'b0;
    int          quiet_cycles = 0;
    int          ticks_sent   = 0;
    int          timeouts_set = 0;

    dock_stage_tracker book = new();

    dock_recruit_handshake_fsm #(
        .PORTS(4)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic logic [3:0] rand_mask(input int pct);
        logic [3:0] m;
        for (int i = 0; i < 4; i++)
            m[i] = ($urandom_range(99) < pct);
        return m;
    endfunction

    task automatic send_tick(input logic [3:0] dr, input logic [3:0] gm,
                             input logic [3:0] lm, input logic [3:0] lk);
        while (gaps_on && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {lk, lm, gm, dr};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.take_tick({lk, lm, gm, dr});
        ticks_sent++;
    endtask

    // Hold the input until every report is in, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_guide_timeout(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.give_up_after = v;
        timeouts_set++;
    endtask

    task automatic random_ticks(input int n, input int dr_pct, input int gm_pct);
        for (int k = 0; k < n; k++)
            send_tick(rand_mask(dr_pct), rand_mask(gm_pct), 4'h0, 4'h0);
    endtask

    // Walk one port from guiding into the lock handshake; the others see only noise.
    task automatic lock_run(input int p, input int variant);
        logic [3:0] own;
        logic [3:0] others;
        own    = 4'b0001 << p;
        others = ~own;
        send_tick(rand_mask(15) & others, own | (rand_mask(25) & others), 4'h0, 4'h0);
        repeat ($urandom_range(0, 2))
            send_tick(rand_mask(15) & others, rand_mask(25) & others, 4'h0, 4'h0);
        case (variant)
            0:
            begin
                // request and lock-me together: give up, lock-me stays pending
                send_tick(own, 4'h0, own, 4'h0);
                send_tick(4'h0, own, 4'h0, 4'h0);
            end
            1:
                send_tick(4'h0, 4'h0, 4'h0, own);
            default:
                send_tick(4'h0, 4'h0, own, own);
        endcase
        repeat (4)
            send_tick(rand_mask(15) & others, rand_mask(25) & others, 4'h0, 4'h0);
    endtask

    // Sink side: random stalls, plus one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= !gaps_on || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.match_report(m_tdata, m_tlast);
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("dock_recruit_handshake_fsm_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: beacons, guiding, request give-up, pending guide-me, reset timeout
        send_tick(4'h0, 4'h0, 4'h0, 4'h0);
        send_tick(4'hF, 4'h0, 4'h0, 4'h0);
        send_tick(4'h0, 4'h5, 4'h0, 4'h0);
        send_tick(4'h0, 4'hA, 4'h0, 4'h0);
        send_tick(4'h0, 4'hF, 4'h0, 4'h0);
        send_tick(4'h0, 4'h0, 4'h0, 4'h0);
        send_tick(4'h3, 4'h0, 4'h0, 4'h0);
        send_tick(4'hF, 4'hF, 4'h0, 4'h0);
        send_tick(4'h0, 4'h0, 4'h0, 4'h0);
        drain();
        set_guide_timeout(16'd1);
        repeat (3) send_tick(4'h0, 4'h0, 4'h0, 4'h0);
        send_tick(4'h0, 4'hF, 4'h0, 4'h0);
        repeat (3) send_tick(4'h0, 4'h0, 4'h0, 4'h0);

        random_ticks(90, 10, 30);
        drain();

        // no idling on either side for this stretch
        set_guide_timeout(16'hFFFF);
        gaps_on = 1'b0;
        random_ticks(70, 20, 30);
        drain();
        gaps_on = 1'b1;

        set_guide_timeout(16'($urandom_range(2, 6)));
        hold_ask = 1'b1;
        random_ticks(90, 12, 25);
        drain();

        set_guide_timeout(16'd10);
        for (int p = 0; p < 4; p++)
            lock_run(p, (p == 3) ? $urandom_range(0, 2) : p);
        repeat (6)
            send_tick(rand_mask(20), rand_mask(30), rand_mask(20), rand_mask(20));
        send_tick(4'hF, 4'hF, 4'hF, 4'hF);
        send_tick(4'h0, 4'h0, 4'h0, 4'h0);
        drain();

        $display("%0d ticks sent, %0d port reports checked, %0d guide timeouts programmed",
                 ticks_sent, book.seen, timeouts_set);
        $display("paths: beacons, guiding, give-ups, lock-me and locked endings, hold-off");
        if (book.errors == 0 && book.reports.size() == 0)
            $display("dock_recruit_handshake_fsm_tb: done, clean");
        else
            $display("dock_recruit_handshake_fsm_tb: done, errors");
        $finish;
    end
endmodule
